[hdl/pps_pkg.sv]
package pps_pkg;

  localparam int COORD_W     = 32;
  localparam int LW_W        = 16;
  localparam int THR_W       = LW_W - 2;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_MODE       = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WIDTH = 1'b1;

  localparam logic            MODE_COLLINEAR = 1'b0;
  localparam logic            MODE_MERGE     = 1'b1;
  localparam logic [LW_W-1:0] LW_RESET       = 16'd400;

  typedef enum logic [1:0] {
    KIND_ANCHOR = 2'd0,
    KIND_POINT  = 2'd1,
    KIND_FINAL  = 2'd2
  } kind_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    kind_t                     kind;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      path_end;
  } out_item_t;

  typedef struct packed {
    logic            mode;
    logic [LW_W-1:0] bead_width;
  } cfg_t;

endpackage

[hdl/pps_if.sv]
interface pps_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [pps_pkg::COORD_W-1:0] in_x;
  logic signed [pps_pkg::COORD_W-1:0] in_y;
  logic                               is_anchor;
  logic                               is_final;

  modport source (output valid, in_x, in_y, is_anchor, is_final, input ready);
  modport sink   (input valid, in_x, in_y, is_anchor, is_final, output ready);
endinterface

interface pps_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pps_pkg::COORD_W-1:0] out_x;
  logic signed [pps_pkg::COORD_W-1:0] out_y;
  logic                               path_end;

  modport source (output valid, out_x, out_y, path_end, input ready);
  modport sink   (input valid, out_x, out_y, path_end, output ready);
endinterface

interface pps_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [pps_pkg::CFG_INDEX_W-1:0]        reg_index;
  logic [pps_pkg::LW_W-1:0]               wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

[hdl/polyline_point_simplifier.sv]
// channel  dir  handshake            payload
// in_ch    in   valid/ready          in_x, in_y, is_anchor, is_final
// out_ch   out  valid/ready          out_x, out_y, path_end
// cfg_ch   in   valid/ready (ready=1) reg_index, wdata
//
// One request per cycle while the output buffer has room; a final point may put two results
// into the two-entry output buffer, which drains one per cycle while out_ch.ready is high.
// A request is queued, decided at the queue head, then registered in the output buffer.
// The decision unit fires only when the output buffer can take the request's worst case.
// Output stalls back up into the QUEUE_DEPTH-entry queue, then in_ch.ready drops.
// rst_n is synchronous, active low; no clearing pass, the block is ready right after reset.
module polyline_point_simplifier #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  pps_in_if.sink    in_ch,
  pps_out_if.source out_ch,
  pps_cfg_if.sink   cfg_ch
);

  pps_pkg::cfg_t   cfg_r;
  pps_pkg::cfg_t   cfg_nxt;
  pps_pkg::point_t q_data;
  logic            q_valid;
  logic            q_pop;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        pps_pkg::CFG_MODE:       cfg_nxt.mode       = cfg_ch.wdata[0];
        pps_pkg::CFG_LINE_WIDTH: cfg_nxt.bead_width = cfg_ch.wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode       <= pps_pkg::MODE_COLLINEAR;
      cfg_r.bead_width <= pps_pkg::LW_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pps_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  pps_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

[hdl/pps_front.sv]
module pps_front #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  pps_in_if.sink          in_ch,
  output pps_pkg::point_t q_data,
  output logic            q_valid,
  input  logic            q_pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pps_pkg::point_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  pps_pkg::point_t  entry;
  logic             push;

  always_comb begin
    entry.x = in_ch.in_x;
    entry.y = in_ch.in_y;
    priority if (in_ch.is_anchor) begin
      entry.kind = pps_pkg::KIND_ANCHOR;
    end else if (in_ch.is_final) begin
      entry.kind = pps_pkg::KIND_FINAL;
    end else begin
      entry.kind = pps_pkg::KIND_POINT;
    end
  end

  assign in_ch.ready = (cnt_r != CNT_W'(DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign q_data      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

endmodule

[hdl/pps_back.sv]
module pps_back (
  input  logic            clk,
  input  logic            rst_n,
  input  pps_pkg::cfg_t   cfg,
  input  pps_pkg::point_t q_data,
  input  logic            q_valid,
  output logic            q_pop,
  pps_out_if.source       out_ch
);

  localparam int W      = pps_pkg::COORD_W;
  localparam int TW     = pps_pkg::THR_W;
  localparam int OB_CNT = 2;
  localparam logic [1:0] OB_DEPTH = 2'd2;

  logic signed [W-1:0] ref_x_r, ref_y_r, ref_x_nxt, ref_y_nxt;
  logic signed [W-1:0] held_x_r, held_y_r, held_x_nxt, held_y_nxt;
  logic                ref_valid_r, ref_valid_nxt;
  logic                held_valid_r, held_valid_nxt;

  pps_pkg::out_item_t ob_r [OB_CNT];
  pps_pkg::out_item_t ob_nxt [OB_CNT];
  logic [1:0]         ob_cnt_r, ob_cnt_nxt;
  logic               ob_pop;
  logic [1:0]         cnt_keep, free_slots, need;

  pps_pkg::out_item_t wr_data [OB_CNT];
  logic [1:0]         wr_cnt;

  logic signed [W:0]     d1x, d1y, d2x, d2y;
  logic signed [2*W+1:0] p1, p2;
  logic                  coll;
  logic [W:0]            adx, ady;
  logic [TW-1:0]         thr;
  logic [2*TW-1:0]       sqx, sqy, thr_sq;
  logic [2*TW:0]         sq_sum;
  logic                  near;
  logic [W:0]            sum_x, sum_y, adj_x, adj_y;
  logic signed [W-1:0]   mid_x, mid_y;
  logic                  is_final, emit_held, merge;

  // geometry
  always_comb begin
    d1x = {held_x_r[W-1], held_x_r} - {ref_x_r[W-1], ref_x_r};
    d1y = {held_y_r[W-1], held_y_r} - {ref_y_r[W-1], ref_y_r};
    d2x = {q_data.x[W-1], q_data.x} - {held_x_r[W-1], held_x_r};
    d2y = {q_data.y[W-1], q_data.y} - {held_y_r[W-1], held_y_r};
    p1  = d1x * d2y;
    p2  = d1y * d2x;
    coll = (p1 == p2);

    adx = d2x[W] ? (W+1)'(-d2x) : (W+1)'(d2x);
    ady = d2y[W] ? (W+1)'(-d2y) : (W+1)'(d2y);
    thr = cfg.bead_width[pps_pkg::LW_W-1:2];
    sqx = adx[TW-1:0] * adx[TW-1:0];
    sqy = ady[TW-1:0] * ady[TW-1:0];
    thr_sq = thr * thr;
    sq_sum = {1'b0, sqx} + {1'b0, sqy};
    near = (adx < (W+1)'(thr)) && (ady < (W+1)'(thr)) && (sq_sum < {1'b0, thr_sq});

    // midpoint rounded toward zero
    sum_x = {held_x_r[W-1], held_x_r} + {q_data.x[W-1], q_data.x};
    sum_y = {held_y_r[W-1], held_y_r} + {q_data.y[W-1], q_data.y};
    adj_x = sum_x + (W+1)'(sum_x[W]);
    adj_y = sum_y + (W+1)'(sum_y[W]);
    mid_x = adj_x[W:1];
    mid_y = adj_y[W:1];
  end

  // request fires when the output buffer has room for its worst case
  always_comb begin
    unique case (q_data.kind)
      pps_pkg::KIND_ANCHOR: need = 2'd0;
      pps_pkg::KIND_POINT:  need = 2'd1;
      pps_pkg::KIND_FINAL:  need = 2'd2;
      default:              need = 2'd0;
    endcase
  end

  assign ob_pop     = (ob_cnt_r != 2'd0) && out_ch.ready;
  assign cnt_keep   = ob_cnt_r - 2'(ob_pop);
  assign free_slots = OB_DEPTH - cnt_keep;
  assign q_pop      = q_valid && (need <= free_slots);

  assign is_final = (q_data.kind == pps_pkg::KIND_FINAL);

  always_comb begin
    if (cfg.mode == pps_pkg::MODE_COLLINEAR) begin
      emit_held = held_valid_r && !(ref_valid_r && coll);
    end else begin
      emit_held = held_valid_r && (is_final || !near);
    end
    merge = held_valid_r && (cfg.mode == pps_pkg::MODE_MERGE) && !is_final && near;
  end

  always_comb begin
    ref_x_nxt      = ref_x_r;
    ref_y_nxt      = ref_y_r;
    ref_valid_nxt  = ref_valid_r;
    held_x_nxt     = held_x_r;
    held_y_nxt     = held_y_r;
    held_valid_nxt = held_valid_r;
    wr_cnt         = 2'd0;
    wr_data[0]     = '{x: held_x_r, y: held_y_r, path_end: 1'b0};
    wr_data[1]     = '{x: q_data.x, y: q_data.y, path_end: 1'b1};
    if (q_pop) begin
      unique case (q_data.kind)
        pps_pkg::KIND_ANCHOR: begin
          ref_x_nxt     = q_data.x;
          ref_y_nxt     = q_data.y;
          ref_valid_nxt = 1'b1;
        end
        pps_pkg::KIND_POINT, pps_pkg::KIND_FINAL: begin
          if (emit_held) begin
            wr_cnt = 2'd1;
            if (cfg.mode == pps_pkg::MODE_COLLINEAR) begin
              ref_x_nxt     = held_x_r;
              ref_y_nxt     = held_y_r;
              ref_valid_nxt = 1'b1;
            end
          end
          if (is_final) begin
            if (emit_held) begin
              wr_cnt = 2'd2;
            end else begin
              wr_cnt     = 2'd1;
              wr_data[0] = '{x: q_data.x, y: q_data.y, path_end: 1'b1};
            end
            held_valid_nxt = 1'b0;
            ref_valid_nxt  = 1'b0;
          end else begin
            held_x_nxt     = merge ? mid_x : q_data.x;
            held_y_nxt     = merge ? mid_y : q_data.y;
            held_valid_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output buffer: shift on pop, append up to two
  always_comb begin
    ob_nxt[0] = ob_pop ? ob_r[1] : ob_r[0];
    ob_nxt[1] = ob_r[1];
    if (cnt_keep == 2'd0 && wr_cnt != 2'd0) begin
      ob_nxt[0] = wr_data[0];
    end
    if (cnt_keep == 2'd0 && wr_cnt == 2'd2) begin
      ob_nxt[1] = wr_data[1];
    end else if (cnt_keep == 2'd1 && wr_cnt != 2'd0) begin
      ob_nxt[1] = wr_data[0];
    end
    ob_cnt_nxt = cnt_keep + wr_cnt;
  end

  assign out_ch.valid    = (ob_cnt_r != 2'd0);
  assign out_ch.out_x    = ob_r[0].x;
  assign out_ch.out_y    = ob_r[0].y;
  assign out_ch.path_end = ob_r[0].path_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_valid_r  <= 1'b0;
      held_valid_r <= 1'b0;
      ob_cnt_r     <= 2'd0;
    end else begin
      ref_valid_r  <= ref_valid_nxt;
      held_valid_r <= held_valid_nxt;
      ob_cnt_r     <= ob_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ref_x_r  <= ref_x_nxt;
    ref_y_r  <= ref_y_nxt;
    held_x_r <= held_x_nxt;
    held_y_r <= held_y_nxt;
    ob_r[0]  <= ob_nxt[0];
    ob_r[1]  <= ob_nxt[1];
  end

`ifndef ASSERT_OFF
  a_ob_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (ob_cnt_nxt <= OB_DEPTH))
    else $error("output buffer overflow");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_data.kind == pps_pkg::KIND_FINAL) |=> (!held_valid_r && !ref_valid_r))
    else $error("path state not cleared after final point");

  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_data.kind == pps_pkg::KIND_FINAL) |->
      ((wr_cnt == 2'd1 && wr_data[0].path_end) || (wr_cnt == 2'd2 && wr_data[1].path_end
        && !wr_data[0].path_end)))
    else $error("final point not written last with path_end");

  a_anchor_ref: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_data.kind == pps_pkg::KIND_ANCHOR) |=>
      (ref_valid_r && held_valid_r == $past(held_valid_r) && ob_cnt_r <= $past(ob_cnt_r)))
    else $error("anchor request disturbed held point or output");
`endif

endmodule
